[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and an index helper for the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]                  mode;
    logic signed [WORD_BITS-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] item;
    logic [1:0]                  status;
    logic                        last;
  } deq_out_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       rd;
    logic       commit;
    logic       dcnt_inc;
    logic       out_load;
    logic       out_data;
    logic [1:0] out_code;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0]       mode;
    logic             full;
    logic             empty;
    logic             out_free;
    logic             dump_last;
    logic [CNT_W-1:0] occ;
  } deq_stat_t;

  // ring index add, both operands below DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words held in a ring buffer memory.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is low until the sequencer is back
// in idle. A decode step finishes a push, an undefined mode, or a pop or dump
// on an empty queue; a pop that removes a word adds a step that loads it, and
// a dump adds a step that loads each stored entry. A step that loads a beat
// waits while the result side stalls; the entry memory's read data is
// registered. Every request with a defined mode yields at least one beat; a
// dump of a non-empty queue yields one beat per stored entry, front to back,
// with last on the back entry. Results leave through an output register, so
// a beat waiting on out_ready does not block the next step until another
// beat must be loaded. Undefined modes are dropped silently.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire deq_pkg::deq_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output deq_pkg::deq_out_t     out_data
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.occ <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("occupancy above depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output beat overwritten");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (stat.mode == deq_pkg::MODE_PUSH_FRONT ||
                    stat.mode == deq_pkg::MODE_PUSH_BACK))
    |=> stat.occ == $past(stat.occ) + deq_pkg::CNT_W'(1))
    else $error("push did not grow queue");
`endif

endmodule

`default_nettype wire

[rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: decodes one request and steps the datapath through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_code = deq_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.mode)
          deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_code = deq_pkg::ST_FULL;
              end else begin
                cmd.commit = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK,
          deq_pkg::MODE_DUMP: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load = 1'b1;
                cmd.out_code = deq_pkg::ST_EMPTY;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.rd    = 1'b1;
              state_nxt = (stat.mode == deq_pkg::MODE_DUMP) ? S_DUMP : S_POP;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_data = 1'b1;
          cmd.commit   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_data = 1'b1;
          if (stat.dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.dcnt_inc = 1'b1;
            cmd.rd       = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/deq_dp.sv]
// ----------------------------------------------------------------------------
// deq_dp
// Ring buffer datapath: entry memory, front pointer, occupancy, output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire deq_pkg::deq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output deq_pkg::deq_out_t      out_data,
  input  wire deq_pkg::deq_cmd_t cmd,
  output deq_pkg::deq_stat_t     stat
);

  logic signed [deq_pkg::WORD_BITS-1:0] mem [deq_pkg::DEPTH];

  deq_pkg::deq_in_t                     op_r;
  logic [deq_pkg::ADDR_W-1:0]           front_r;
  logic [deq_pkg::ADDR_W-1:0]           front_nxt;
  logic [deq_pkg::CNT_W-1:0]            occ_r;
  logic [deq_pkg::CNT_W-1:0]            occ_nxt;
  logic [deq_pkg::ADDR_W-1:0]           dcnt_r;
  logic [deq_pkg::ADDR_W-1:0]           dcnt_nxt;
  logic signed [deq_pkg::WORD_BITS-1:0] rdata_r;
  logic                                 out_valid_r;
  deq_pkg::deq_out_t                    out_r;

  logic [deq_pkg::ADDR_W-1:0] occ_lo;
  logic [deq_pkg::ADDR_W-1:0] occ_m1;
  logic [deq_pkg::ADDR_W-1:0] front_dec;
  logic [deq_pkg::ADDR_W-1:0] rd_addr;
  logic [deq_pkg::ADDR_W-1:0] wr_addr;
  logic                       wr_en;
  logic                       is_push;

  assign occ_lo    = occ_r[deq_pkg::ADDR_W-1:0];
  assign occ_m1    = occ_lo - deq_pkg::ADDR_W'(1);
  assign front_dec = deq_pkg::wrap_add(front_r, deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1));
  assign dcnt_nxt  = cmd.dcnt_inc ? dcnt_r + deq_pkg::ADDR_W'(1) : dcnt_r;
  assign is_push   = (op_r.mode == deq_pkg::MODE_PUSH_FRONT) ||
                     (op_r.mode == deq_pkg::MODE_PUSH_BACK);
  assign wr_en     = cmd.commit && is_push;

  always_comb begin
    case (op_r.mode)
      deq_pkg::MODE_POP_FRONT: rd_addr = front_r;
      deq_pkg::MODE_POP_BACK:  rd_addr = deq_pkg::wrap_add(front_r, occ_m1);
      default:                 rd_addr = deq_pkg::wrap_add(front_r, dcnt_nxt);
    endcase
  end

  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    wr_addr   = deq_pkg::wrap_add(front_r, occ_lo);
    case (op_r.mode)
      deq_pkg::MODE_PUSH_FRONT: begin
        wr_addr = front_dec;
        if (cmd.commit) begin
          front_nxt = front_dec;
          occ_nxt   = occ_r + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::MODE_PUSH_BACK: begin
        if (cmd.commit) begin
          occ_nxt = occ_r + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (cmd.commit) begin
          front_nxt = deq_pkg::wrap_add(front_r, deq_pkg::ADDR_W'(1));
          occ_nxt   = occ_r - deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::MODE_POP_BACK: begin
        if (cmd.commit) begin
          occ_nxt = occ_r - deq_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= op_r.value;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_data;
    end
    if (cmd.latch) begin
      dcnt_r <= '0;
    end else begin
      dcnt_r <= dcnt_nxt;
    end
    if (cmd.out_load) begin
      out_r.item   <= cmd.out_data ? rdata_r : '0;
      out_r.status <= cmd.out_code;
      out_r.last   <= (op_r.mode == deq_pkg::MODE_DUMP && cmd.out_data) ?
                      stat.dump_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.mode      = op_r.mode;
  assign stat.full      = (occ_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign stat.empty     = (occ_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.dump_last = ({1'b0, dcnt_r} == (occ_r - deq_pkg::CNT_W'(1)));
  assign stat.occ       = occ_r;

endmodule

`default_nettype wire

[tb/deq_tb_pkg.sv]
// ----------------------------------------------------------------------------
// deq_tb_pkg
// Scoreboard for the double-ended queue testbench: keeps its own ring
// buffer, predicts the result beats of every accepted request and checks
// each beat taken from the block against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_tb_pkg;

  import deq_pkg::*;

  class deq_scoreboard;

    logic signed [WORD_BITS-1:0] ring [DEPTH];
    logic [ADDR_W-1:0]           head;
    logic [CNT_W-1:0]            fill;
    deq_out_t                    awaited [$];

    int errors;
    int n_push_ok;
    int n_full;
    int n_pop_ok;
    int n_empty;
    int n_dump;
    int n_ignored;
    int n_beats;

    function new();
      head      = '0;
      fill      = '0;
      errors    = 0;
      n_push_ok = 0;
      n_full    = 0;
      n_pop_ok  = 0;
      n_empty   = 0;
      n_dump    = 0;
      n_ignored = 0;
      n_beats   = 0;
      foreach (ring[k]) ring[k] = '0;
    endfunction

    function int slot_of(int offset);
      return (int'(head) + offset) % DEPTH;
    endfunction

    function void add_beat(logic signed [WORD_BITS-1:0] item, logic [1:0] status,
                           logic last);
      deq_out_t beat;
      beat.item   = item;
      beat.status = status;
      beat.last   = last;
      awaited.push_back(beat);
    endfunction

    // predict the beats of one accepted request and update the ring
    function void note_request(deq_in_t req);
      int k;
      case (req.mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (fill == CNT_W'(DEPTH)) begin
            n_full++;
            add_beat('0, ST_FULL, 1'b1);
          end else begin
            if (req.mode == MODE_PUSH_FRONT) begin
              head = ADDR_W'(slot_of(DEPTH - 1));
              ring[head] = req.value;
            end else begin
              ring[slot_of(int'(fill))] = req.value;
            end
            fill = fill + 1'b1;
            n_push_ok++;
            add_beat('0, ST_OK, 1'b1);
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (fill == '0) begin
            n_empty++;
            add_beat('0, ST_EMPTY, 1'b1);
          end else begin
            if (req.mode == MODE_POP_FRONT) begin
              add_beat(ring[head], ST_OK, 1'b1);
              head = ADDR_W'(slot_of(1));
            end else begin
              add_beat(ring[slot_of(int'(fill) - 1)], ST_OK, 1'b1);
            end
            fill = fill - 1'b1;
            n_pop_ok++;
          end
        end
        MODE_DUMP: begin
          n_dump++;
          if (fill == '0) begin
            n_empty++;
            add_beat('0, ST_EMPTY, 1'b1);
          end else begin
            for (k = 0; k < int'(fill); k++) begin
              add_beat(ring[slot_of(k)], ST_OK, (k + 1 == int'(fill)));
            end
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_beat(deq_out_t got);
      deq_out_t want;
      n_beats++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat item=%0d status=%0d last=%0d", $time,
                 got.item, got.status, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got.item !== want.item) begin
        errors++;
        $display("%0t: item mismatch, expected %0d, actual %0d", $time, want.item,
                 got.item);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                 want.status, got.status);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0d, actual %0d", $time, want.last,
                 got.last);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void report_leftover();
      foreach (awaited[k]) begin
        errors++;
        $display("%0t: missing beat, expected item=%0d status=%0d last=%0d", $time,
                 awaited[k].item, awaited[k].status, awaited[k].last);
      end
    endfunction

  endclass

endpackage

[tb/double_ended_queue_test.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives push, pop and dump requests into the double-ended queue under
// several idle and stall patterns, including a long receiver hold-off that
// backs the block up, and checks every result beat against a scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_test;

  import deq_pkg::*;
  import deq_tb_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         HOLD_CYCLES   = 150;
  localparam int         RANDOM_ITEMS  = 52;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  deq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  deq_out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  deq_scoreboard sb = new();

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // both handshakes sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_beat(out_data);
    end
  end

  function automatic logic signed [WORD_BITS-1:0] pick_word();
    case ($urandom_range(7))
      0: return {1'b0, {(WORD_BITS-1){1'b1}}};
      1: return {1'b1, {(WORD_BITS-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  function automatic deq_in_t random_request(int push_pct);
    deq_in_t req;
    int      r;
    r = $urandom_range(99);
    req.value = pick_word();
    if (r < 3) begin
      req.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    end else if ($urandom_range(99) < push_pct) begin
      req.mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    end else begin
      case ($urandom_range(4))
        0, 1: req.mode = MODE_POP_FRONT;
        2, 3: req.mode = MODE_POP_BACK;
        default: req.mode = MODE_DUMP;
      endcase
    end
    return req;
  endfunction

  task automatic send_request(input deq_in_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_op(input logic [2:0] mode, input logic signed [WORD_BITS-1:0] value);
    deq_in_t req;
    req.mode  = mode;
    req.value = value;
    send_request(req);
  endtask

  task automatic run_random(input int count);
    int      done;
    int      push_pct;
    deq_in_t req;
    done = 0;
    while (done < count) begin
      case ((done / 13) % 4)
        0: push_pct = 85;
        1: push_pct = 50;
        2: push_pct = 15;
        default: push_pct = 60;
      endcase
      req = random_request(push_pct);
      send_request(req);
      if (req.mode <= MODE_DUMP) done++;
    end
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue and ignored modes
    send_op(MODE_DUMP, 32'sd5);
    send_op(MODE_POP_FRONT, 32'sd1);
    send_op(MODE_POP_BACK, -32'sd1);
    for (k = int'(MODE_SPARE_LO); k <= int'(MODE_SPARE_HI); k++) begin
      send_op(3'(k), pick_word());
    end

    // fill from both ends, starting with extreme words
    send_op(MODE_PUSH_FRONT, 32'sh7fffffff);
    send_op(MODE_PUSH_BACK, 32'sh80000000);
    send_op(MODE_PUSH_FRONT, 32'sh00000000);
    send_op(MODE_PUSH_BACK, 32'shffffffff);
    send_op(MODE_PUSH_FRONT, 32'sh55555555);
    send_op(MODE_PUSH_BACK, 32'shaaaaaaaa);
    for (k = 0; k < DEPTH - 6; k++) begin
      send_op(k[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, WORD_BITS'($urandom));
    end
    send_op(MODE_PUSH_FRONT, 32'sd7);
    send_op(MODE_PUSH_BACK, 32'sd8);
    send_op(MODE_DUMP, '0);
    send_op(MODE_POP_FRONT, '0);
    send_op(MODE_POP_BACK, '0);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_ITEMS);
    send_idle_pct  = 47;
    recv_stall_pct = 0;
    run_random(RANDOM_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 47;
    run_random(RANDOM_ITEMS);
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_random(RANDOM_ITEMS);

    // receiver holds off while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token     = hold_token + 1;
    for (k = 0; k < 24; k++) begin
      send_op((k % 6 == 5) ? MODE_DUMP : MODE_PUSH_BACK, pick_word());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
    sb.report_leftover();

    $display("run covered %0d pushes, %0d full drops, %0d pops, %0d empty answers,",
             sb.n_push_ok, sb.n_full, sb.n_pop_ok, sb.n_empty);
    $display("%0d dumps, %0d ignored requests and %0d checked beats",
             sb.n_dump, sb.n_ignored, sb.n_beats);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
tb/deq_tb_pkg.sv
tb/double_ended_queue_test.sv
